// File: design/tsqc_pkg.sv
// ----------------------------------------------------------------------------
// tsqc_pkg
// Types, constants and helpers shared by the touch qualify/calibrate block.
// ----------------------------------------------------------------------------
`default_nettype none

package tsqc_pkg;

    localparam int ADC_W    = 10;
    localparam int THR_W    = 8;
    localparam int COEF_W   = 32;
    localparam int PIX_W    = 16;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int PROD_W   = COEF_W + ADC_W + 1;   // 32 x 11 signed product
    localparam int SUM_W    = PROD_W + 2;           // three-term sum
    localparam int QUOT_W   = 18;                   // quotient bits kept before clamping
    localparam int FIN_W    = QUOT_W + 3;           // signed room for height minus q
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int DISPLAY_HEIGHT_DEF = 320;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_UNCAL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_THRESH   = 3'd0,
        REG_XX       = 3'd1,
        REG_XY       = 3'd2,
        REG_XOFF     = 3'd3,
        REG_YX       = 3'd4,
        REG_YY       = 3'd5,
        REG_YOFF     = 3'd6,
        REG_DIVIDER  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]         thresh;
        logic signed [COEF_W-1:0] xx;
        logic signed [COEF_W-1:0] xy;
        logic signed [COEF_W-1:0] xoff;
        logic signed [COEF_W-1:0] yx;
        logic signed [COEF_W-1:0] yy;
        logic signed [COEF_W-1:0] yoff;
        logic signed [COEF_W-1:0] divider;
    } cfg_t;

    // Classified request as it leaves the front end.
    typedef struct packed {
        logic              calc;
        status_t           status;
        logic [ADC_W-1:0]  p1;
        logic [ADC_W-1:0]  p2;
        logic [ADC_W-1:0]  rx;
        logic [ADC_W-1:0]  ry;
        logic              land;
    } req_t;

    typedef struct packed {
        logic                    touch_valid;
        status_t                 status;
        logic [ADC_W-1:0]        p1;
        logic [ADC_W-1:0]        p2;
        logic [ADC_W-1:0]        rx;
        logic [ADC_W-1:0]        ry;
        logic signed [PIX_W-1:0] dx;
        logic signed [PIX_W-1:0] dy;
    } result_t;

    function automatic logic signed [PIX_W-1:0] sat16(input logic signed [FIN_W-1:0] v);
        logic signed [FIN_W-1:0] hi;
        logic signed [FIN_W-1:0] lo;
        hi = FIN_W'(32767);
        lo = -FIN_W'(32768);
        if (v > hi)
            return PIX_W'(hi);
        else if (v < lo)
            return PIX_W'(lo);
        else
            return v[PIX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: design/tsqc_in_if.sv
// ----------------------------------------------------------------------------
// tsqc_in_if
// Sample-set channel: valid/ready handshake with the raw readings.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsqc_in_if;
    logic                         valid;
    logic                         ready;
    logic [tsqc_pkg::ADC_W-1:0]   pressure_first;
    logic [tsqc_pkg::ADC_W-1:0]   pressure_second;
    logic [tsqc_pkg::ADC_W-1:0]   x_sample_a;
    logic [tsqc_pkg::ADC_W-1:0]   x_sample_b;
    logic [tsqc_pkg::ADC_W-1:0]   y_sample_a;
    logic [tsqc_pkg::ADC_W-1:0]   y_sample_b;
    logic                         landscape;

    modport source (output valid, pressure_first, pressure_second, x_sample_a,
                    x_sample_b, y_sample_a, y_sample_b, landscape, input ready);
    modport sink   (input valid, pressure_first, pressure_second, x_sample_a,
                    x_sample_b, y_sample_a, y_sample_b, landscape, output ready);
endinterface

`default_nettype wire

// File: design/tsqc_out_if.sv
// ----------------------------------------------------------------------------
// tsqc_out_if
// Result channel: valid/ready handshake with the qualified touch point.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsqc_out_if;
    logic                                valid;
    logic                                ready;
    logic                                touch_valid;
    logic [1:0]                          status;
    logic [tsqc_pkg::ADC_W-1:0]          pressure_one;
    logic [tsqc_pkg::ADC_W-1:0]          pressure_two;
    logic [tsqc_pkg::ADC_W-1:0]          raw_x;
    logic [tsqc_pkg::ADC_W-1:0]          raw_y;
    logic signed [tsqc_pkg::PIX_W-1:0]   display_x;
    logic signed [tsqc_pkg::PIX_W-1:0]   display_y;

    modport source (output valid, touch_valid, status, pressure_one, pressure_two,
                    raw_x, raw_y, display_x, display_y, input ready);
    modport sink   (input valid, touch_valid, status, pressure_one, pressure_two,
                    raw_x, raw_y, display_x, display_y, output ready);
endinterface

`default_nettype wire

// File: design/tsqc_cfg.sv
// ----------------------------------------------------------------------------
// tsqc_cfg
// APB register file holding the threshold and calibration coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module tsqc_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tsqc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tsqc_pkg::DATA_W-1:0]   pwdata,
    output logic      [tsqc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output tsqc_pkg::cfg_t                     cfg
);
    import tsqc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_THRESH:  cfg_reg.thresh  <= pwdata[THR_W-1:0];
                REG_XX:      cfg_reg.xx      <= pwdata;
                REG_XY:      cfg_reg.xy      <= pwdata;
                REG_XOFF:    cfg_reg.xoff    <= pwdata;
                REG_YX:      cfg_reg.yx      <= pwdata;
                REG_YY:      cfg_reg.yy      <= pwdata;
                REG_YOFF:    cfg_reg.yoff    <= pwdata;
                REG_DIVIDER: cfg_reg.divider <= pwdata;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_THRESH:  prdata = DATA_W'(cfg_reg.thresh);
            REG_XX:      prdata = cfg_reg.xx;
            REG_XY:      prdata = cfg_reg.xy;
            REG_XOFF:    prdata = cfg_reg.xoff;
            REG_YX:      prdata = cfg_reg.yx;
            REG_YY:      prdata = cfg_reg.yy;
            REG_YOFF:    prdata = cfg_reg.yoff;
            REG_DIVIDER: prdata = cfg_reg.divider;
            default:     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: design/tsqc_front.sv
// ----------------------------------------------------------------------------
// tsqc_front
// Takes sample sets and classifies them: no touch, mismatch, uncalibrated
// or to be calibrated.
// ----------------------------------------------------------------------------
`default_nettype none

module tsqc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tsqc_pkg::cfg_t cfg,
    tsqc_in_if.sink             sample,
    output logic                push_valid,
    input  wire logic           push_ready,
    output tsqc_pkg::req_t      push_req
);
    import tsqc_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    req_t req_next;
    logic take;

    assign sample.ready = !valid_reg || push_ready;
    assign take         = sample.valid && sample.ready;
    assign push_valid   = valid_reg;
    assign push_req     = req_reg;

    always_comb
    begin
        req_next.p1     = sample.pressure_first;
        req_next.p2     = sample.pressure_second;
        req_next.land   = sample.landscape;
        req_next.rx     = sample.x_sample_a;
        req_next.ry     = sample.y_sample_a;
        req_next.calc   = 1'b0;
        req_next.status = ST_NONE;
        if (sample.pressure_first < ADC_W'(cfg.thresh))
        begin
            req_next.rx = '0;
            req_next.ry = '0;
        end
        else if (sample.x_sample_a != sample.x_sample_b ||
                 sample.y_sample_a != sample.y_sample_b)
        begin
            req_next.status = ST_MISMATCH;
        end
        else if (cfg.divider == '0)
        begin
            req_next.status = ST_UNCAL;
        end
        else
        begin
            req_next.calc = 1'b1;
        end
    end

    assign valid_next = take ? 1'b1 : (push_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            req_reg <= req_next;
    end

endmodule

`default_nettype wire

// File: design/tsqc_queue.sv
// ----------------------------------------------------------------------------
// tsqc_queue
// Short FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tsqc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire tsqc_pkg::req_t push_req,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output tsqc_pkg::req_t      pop_req
);
    import tsqc_pkg::*;

    req_t                mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_req    = mem_reg[rptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_req;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count above depth");

    a_no_phantom_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 && !push_valid) |=> (count_reg == '0))
        else $error("queue filled without a push");

endmodule

`default_nettype wire

// File: design/tsqc_back.sv
// ----------------------------------------------------------------------------
// tsqc_back
// Calibration pipeline: products, sums, magnitudes, a bit-per-stage divider,
// then orientation, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsqc_back #(
    parameter int DISPLAY_HEIGHT = tsqc_pkg::DISPLAY_HEIGHT_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tsqc_pkg::cfg_t cfg,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire tsqc_pkg::req_t pop_req,
    tsqc_out_if.source          result
);
    import tsqc_pkg::*;

    localparam int DEN_W = COEF_W;
    localparam int CMP_W = SUM_W + QUOT_W;

    logic en;

    // Stage 1: products
    logic                      v1_reg;
    req_t                      m1_reg;
    logic signed [PROD_W-1:0]  pxx_reg, pxy_reg, pyx_reg, pyy_reg;

    // Stage 2: sums
    logic                      v2_reg;
    req_t                      m2_reg;
    logic signed [SUM_W-1:0]   sx_reg, sy_reg;

    // Divider stages; index 0 is the magnitude stage.
    logic                      dv_reg  [QUOT_W+1];
    req_t                      dm_reg  [QUOT_W+1];
    logic [SUM_W-1:0]          rx_reg  [QUOT_W+1];
    logic [SUM_W-1:0]          ry_reg  [QUOT_W+1];
    logic [QUOT_W-1:0]         qx_reg  [QUOT_W+1];
    logic [QUOT_W-1:0]         qy_reg  [QUOT_W+1];
    logic [DEN_W-1:0]          ud_reg  [QUOT_W+1];
    logic                      nx_reg  [QUOT_W+1];
    logic                      ny_reg  [QUOT_W+1];
    logic                      ox_reg  [QUOT_W+1];
    logic                      oy_reg  [QUOT_W+1];

    logic                      out_valid_reg;
    result_t                   out_reg;
    result_t                   out_next;

    assign en        = !out_valid_reg || result.ready;
    assign pop_ready = en;

    // ---------------- stage 1 ----------------
    logic signed [PROD_W-1:0] xa_s, ya_s;
    assign xa_s = PROD_W'($signed({1'b0, pop_req.rx}));
    assign ya_s = PROD_W'($signed({1'b0, pop_req.ry}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg  <= pop_req;
            pxx_reg <= PROD_W'(cfg.xx) * xa_s;
            pxy_reg <= PROD_W'(cfg.xy) * ya_s;
            pyx_reg <= PROD_W'(cfg.yx) * xa_s;
            pyy_reg <= PROD_W'(cfg.yy) * ya_s;
        end
    end

    // ---------------- stage 2 ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_reg <= m1_reg;
            sx_reg <= SUM_W'(pxx_reg) + SUM_W'(pxy_reg) + SUM_W'(cfg.xoff);
            sy_reg <= SUM_W'(pyx_reg) + SUM_W'(pyy_reg) + SUM_W'(cfg.yoff);
        end
    end

    // ---------------- stage 3: magnitudes and range check ----------------
    logic [SUM_W-1:0] unx, uny;
    logic [DEN_W-1:0] ud;
    logic             dneg;
    logic [CMP_W-1:0] dlim;

    assign dneg = cfg.divider[COEF_W-1];
    assign ud   = dneg ? (~cfg.divider + 1'b1) : cfg.divider;
    assign unx  = sx_reg[SUM_W-1] ? (~sx_reg + 1'b1) : sx_reg;
    assign uny  = sy_reg[SUM_W-1] ? (~sy_reg + 1'b1) : sy_reg;
    assign dlim = CMP_W'(ud) << QUOT_W;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dm_reg[0] <= m2_reg;
            rx_reg[0] <= unx;
            ry_reg[0] <= uny;
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            ud_reg[0] <= ud;
            nx_reg[0] <= sx_reg[SUM_W-1] ^ dneg;
            ny_reg[0] <= sy_reg[SUM_W-1] ^ dneg;
            ox_reg[0] <= CMP_W'(unx) >= dlim;
            oy_reg[0] <= CMP_W'(uny) >= dlim;
        end
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    for (genvar g = 0; g < QUOT_W; g++)
    begin : g_div
        localparam int B = QUOT_W - 1 - g;
        logic [CMP_W-1:0] dsh;
        logic [CMP_W-1:0] ex, ey;
        logic             tx, ty;

        assign dsh = CMP_W'(ud_reg[g]) << B;
        assign ex  = CMP_W'(rx_reg[g]);
        assign ey  = CMP_W'(ry_reg[g]);
        assign tx  = ex >= dsh;
        assign ty  = ey >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dm_reg[g+1] <= dm_reg[g];
                ud_reg[g+1] <= ud_reg[g];
                nx_reg[g+1] <= nx_reg[g];
                ny_reg[g+1] <= ny_reg[g];
                ox_reg[g+1] <= ox_reg[g];
                oy_reg[g+1] <= oy_reg[g];
                rx_reg[g+1] <= tx ? SUM_W'(ex - dsh) : rx_reg[g];
                ry_reg[g+1] <= ty ? SUM_W'(ey - dsh) : ry_reg[g];
                qx_reg[g+1] <= qx_reg[g] | (QUOT_W'(tx) << B);
                qy_reg[g+1] <= qy_reg[g] | (QUOT_W'(ty) << B);
            end
        end
    end

    // ---------------- final: sign, orientation, saturation ----------------
    logic [QUOT_W-1:0]        mqx, mqy;
    logic signed [FIN_W-1:0]  sqx, sqy, fdx, fdy;
    req_t                     fm;

    assign fm  = dm_reg[QUOT_W];
    // A quotient past the kept range saturates anyway, so clamp it.
    assign mqx = ox_reg[QUOT_W] ? '1 : qx_reg[QUOT_W];
    assign mqy = oy_reg[QUOT_W] ? '1 : qy_reg[QUOT_W];
    assign sqx = nx_reg[QUOT_W] ? -$signed(FIN_W'(mqx)) : $signed(FIN_W'(mqx));
    assign sqy = ny_reg[QUOT_W] ? -$signed(FIN_W'(mqy)) : $signed(FIN_W'(mqy));

    always_comb
    begin
        if (fm.land)
        begin
            fdx = sqy;
            fdy = $signed(FIN_W'(DISPLAY_HEIGHT)) - sqx;
        end
        else
        begin
            fdx = sqx;
            fdy = sqy;
        end
        out_next.touch_valid = fm.calc;
        out_next.status      = fm.status;
        out_next.p1          = fm.p1;
        out_next.p2          = fm.p2;
        out_next.rx          = fm.rx;
        out_next.ry          = fm.ry;
        out_next.dx          = fm.calc ? sat16(fdx) : '0;
        out_next.dy          = fm.calc ? sat16(fdy) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= QUOT_W; i++)
                dv_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= pop_valid;
            v2_reg        <= v1_reg;
            dv_reg[0]     <= v2_reg;
            for (int i = 0; i < QUOT_W; i++)
                dv_reg[i+1] <= dv_reg[i];
            out_valid_reg <= dv_reg[QUOT_W];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.touch_valid  = out_reg.touch_valid;
    assign result.status       = out_reg.status;
    assign result.pressure_one = out_reg.p1;
    assign result.pressure_two = out_reg.p2;
    assign result.raw_x        = out_reg.rx;
    assign result.raw_y        = out_reg.ry;
    assign result.display_x    = out_reg.dx;
    assign result.display_y    = out_reg.dy;

    a_valid_means_none: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.touch_valid) |-> (out_reg.status == ST_NONE))
        else $error("calibrated touch with a non-zero status");

    a_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.touch_valid) |->
            (out_reg.dx == '0 && out_reg.dy == '0))
        else $error("display point set on a rejected touch");

    a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v1_reg) && $stable(dv_reg[QUOT_W])))
        else $error("pipeline moved during a stall");

endmodule

`default_nettype wire

// File: design/touch_sample_qualify_calibrate_top.sv
// ----------------------------------------------------------------------------
// touch_sample_qualify_calibrate_top
// Qualifies resistive-touch sample sets and maps them to display pixels.
// ----------------------------------------------------------------------------
//  Channel   Dir   Handshake                 Carries
//  sample    in    valid/ready               pressures, X/Y pairs, landscape
//  result    out   valid/ready               status, echoes, display point
//  apb       in    psel/penable, pready=1    threshold, coefficients, divider
//
//  One request per cycle sustained while results are taken; a request passes
//  the front register, the queue, the back end and its 18-stage quotient pipeline.
//  Reset clears the configuration registers, the queue pointers and all
//  pipeline valid bits; data registers are not reset and no clearing pass runs.
//  A stalled result holds the whole back end; the front keeps taking requests
//  until the four-entry queue and the front register fill.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_sample_qualify_calibrate_top #(
    parameter int DISPLAY_HEIGHT = tsqc_pkg::DISPLAY_HEIGHT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tsqc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [tsqc_pkg::DATA_W-1:0]   pwdata,
    output logic      [tsqc_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    tsqc_in_if.sink                            sample,
    tsqc_out_if.source                         result
);
    import tsqc_pkg::*;

    cfg_t cfg;
    logic push_valid, push_ready, pop_valid, pop_ready;
    req_t push_req, pop_req;

    tsqc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsqc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .sample     (sample),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req)
    );

    tsqc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req)
    );

    tsqc_back #(
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_req   (pop_req),
        .result    (result)
    );

endmodule

`default_nettype wire
